// ===== sv/date_day_difference_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the date day difference block.
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef DATE_DAY_DIFFERENCE_ASSERT_SVH
`define DATE_DAY_DIFFERENCE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DDD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("date_day_difference: implication failed");

// Next-cycle implication, checked outside reset.
`define DDD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("date_day_difference: next-cycle check failed");

`endif

// ===== sv/ddd_pkg.sv =====
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared types, constants and the month offset table.
// ----------------------------------------------------------------------------
`default_nettype none

package ddd_pkg;

  localparam int MONTH_W       = 4;
  localparam int DAY_W         = 5;
  localparam int OUT_W         = 23;
  localparam int DOY_W         = 9;
  localparam int DLT_W         = DOY_W + 1;
  localparam int REM_W         = 7;
  localparam int DIVISOR       = 100;
  localparam int DAYS_PER_YEAR = 365;

  // Reciprocal of one hundred scaled by 2**26 and rounded up.
  localparam int RECIP_W       = 20;
  localparam int RECIP_SHIFT   = 26;
  localparam int RECIP_100     = 671089;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic mul;
    logic sum;
    logic finish;
  } ddd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } ddd_status_t;

  // Days before the first of each month in a common year.
  // Codes outside January to December map to zero.
  function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/date_day_difference.sv =====
// An accepted word passes the divide, multiply and sum states, then the output stage.
// The sequencer takes a word only when idle, so it takes none while one is in progress.
// The divide is one reciprocal multiply, so the states do not depend on YEAR_BITS.
// A new word is taken while a finished word still waits on out_stall; the new word
// then waits in the sequencer until the output register frees up.
// Reset (rst, synchronous) returns the sequencer to idle and clears out_valid.
// ----------------------------------------------------------------------------
// date_day_difference
// Days between two Gregorian dates, with a sequencer and a datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module date_day_difference
  import ddd_pkg::*;
#(
  parameter int YEAR_BITS = 14
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [YEAR_BITS-1:0] year_a,
  input  wire logic [MONTH_W-1:0]   month_a,
  input  wire logic [DAY_W-1:0]     day_a,
  input  wire logic [YEAR_BITS-1:0] year_b,
  input  wire logic [MONTH_W-1:0]   month_b,
  input  wire logic [DAY_W-1:0]     day_b,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OUT_W-1:0]          day_difference
);

  ddd_cmd_t    cmd;
  ddd_status_t status;

  ddd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ddd_datapath #(.YEAR_BITS(YEAR_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .year_a         (year_a),
    .month_a        (month_a),
    .day_a          (day_a),
    .year_b         (year_b),
    .month_b        (month_b),
    .day_b          (day_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .day_difference (day_difference)
  );

endmodule

`default_nettype wire

// ===== sv/ddd_div100.sv =====
// ----------------------------------------------------------------------------
// ddd_div100
// Divider by one hundred through a multiply by a scaled reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module ddd_div100
  import ddd_pkg::*;
#(
  parameter int W = 14
) (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic             step,
  input  wire logic [W-1:0]     din,
  output logic      [W-1:0]     quot,
  output logic      [REM_W-1:0] rem
);

  localparam int PROD_W = W + RECIP_W;

  logic [W-1:0]      dvd;
  logic [W-1:0]      q;
  logic [PROD_W-1:0] prod;

  // The reciprocal is rounded up, and the error stays below one hundredth
  // for dividends under about 1.8 million, so the floor comes out exact.
  assign prod = PROD_W'(dvd) * PROD_W'(RECIP_100);

  always_ff @(posedge clk) begin
    if (load) begin
      dvd <= din;
    end else if (step) begin
      q <= W'(prod >> RECIP_SHIFT);
    end
  end

  assign quot = q;
  // The remainder is below 128, so the low bits of the difference are enough.
  assign rem  = dvd[REM_W-1:0] - REM_W'(q[REM_W-1:0] * REM_W'(DIVISOR));

endmodule

`default_nettype wire

// ===== sv/ddd_datapath.sv =====
// ----------------------------------------------------------------------------
// ddd_datapath
// Day counts for both dates, the year span and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddd_datapath
  import ddd_pkg::*;
#(
  parameter int YEAR_BITS = 14
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ddd_cmd_t             cmd,
  output ddd_status_t               status,
  input  wire logic [YEAR_BITS-1:0] year_a,
  input  wire logic [MONTH_W-1:0]   month_a,
  input  wire logic [DAY_W-1:0]     day_a,
  input  wire logic [YEAR_BITS-1:0] year_b,
  input  wire logic [MONTH_W-1:0]   month_b,
  input  wire logic [DAY_W-1:0]     day_b,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OUT_W-1:0]          day_difference
);

  localparam int YB    = YEAR_BITS;
  localparam int DBY_W = YEAR_BITS + 9;
  localparam int SUM_W = (DBY_W + 1 > OUT_W) ? DBY_W + 1 : OUT_W;

  logic [YB-1:0]      ya, yb;
  logic [MONTH_W-1:0] ma, mb;
  logic [DAY_W-1:0]   da, db;
  logic               a_later;

  logic [YB-1:0]      qa1, qa2, qb1, qb2;
  logic [REM_W-1:0]   ra1, ra2, rb1, rb2;

  logic [DBY_W-1:0]   prod_a, prod_b;
  logic [YB-1:0]      lc_a, lc_b;
  logic [DOY_W-1:0]   doy_a, doy_b;
  logic [DBY_W-1:0]   dby_a, dby_b;
  logic signed [DLT_W-1:0] delta;

  logic [DBY_W-1:0]   span;
  logic [SUM_W-1:0]   result;

  // Lanes 1 divide the year by 100, lanes 2 divide the year over four by 100,
  // which gives the year over 400.
  ddd_div100 #(.W(YB)) u_div_a1 (
    .clk(clk), .load(cmd.load), .step(cmd.step),
    .din(year_a), .quot(qa1), .rem(ra1)
  );
  ddd_div100 #(.W(YB)) u_div_a2 (
    .clk(clk), .load(cmd.load), .step(cmd.step),
    .din({2'b00, year_a[YB-1:2]}), .quot(qa2), .rem(ra2)
  );
  ddd_div100 #(.W(YB)) u_div_b1 (
    .clk(clk), .load(cmd.load), .step(cmd.step),
    .din(year_b), .quot(qb1), .rem(rb1)
  );
  ddd_div100 #(.W(YB)) u_div_b2 (
    .clk(clk), .load(cmd.load), .step(cmd.step),
    .din({2'b00, year_b[YB-1:2]}), .quot(qb2), .rem(rb2)
  );

  function automatic logic is_leap(input logic [YB-1:0] y,
                                   input logic [REM_W-1:0] r1,
                                   input logic [REM_W-1:0] r2);
    logic by4;
    by4 = (y[1:0] == 2'b00);
    return by4 && ((r1 != '0) || (r2 == '0));
  endfunction

  // Leap years in years 0 to y-1: ceil(y/4) - ceil(y/100) + ceil(y/400).
  function automatic logic [YB-1:0] leap_count(input logic [YB-1:0] y,
                                               input logic [YB-1:0] q1,
                                               input logic [REM_W-1:0] r1,
                                               input logic [YB-1:0] q2,
                                               input logic [REM_W-1:0] r2);
    logic [YB-1:0] c4, c100, c400;
    c4   = {2'b00, y[YB-1:2]} + YB'(|y[1:0]);
    c100 = q1 + YB'(r1 != '0);
    c400 = q2 + YB'(!((y[1:0] == 2'b00) && (r2 == '0)));
    return c4 - c100 + c400;
  endfunction

  function automatic logic [DOY_W-1:0] day_of_year(input logic [MONTH_W-1:0] m,
                                                   input logic [DAY_W-1:0] d,
                                                   input logic leap);
    logic late;
    late = (m >= 4'd3) && (m <= 4'd12);
    return month_offset(m) + DOY_W'(d) + DOY_W'(late && leap);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ya      <= year_a;
      yb      <= year_b;
      ma      <= month_a;
      mb      <= month_b;
      da      <= day_a;
      db      <= day_b;
      a_later <= (year_a > year_b);
    end
    if (cmd.mul) begin
      prod_a <= DBY_W'(ya) * DBY_W'(DAYS_PER_YEAR);
      prod_b <= DBY_W'(yb) * DBY_W'(DAYS_PER_YEAR);
      lc_a   <= leap_count(ya, qa1, ra1, qa2, ra2);
      lc_b   <= leap_count(yb, qb1, rb1, qb2, rb2);
      doy_a  <= day_of_year(ma, da, is_leap(ya, ra1, ra2));
      doy_b  <= day_of_year(mb, db, is_leap(yb, rb1, rb2));
    end
    if (cmd.sum) begin
      dby_a <= prod_a + DBY_W'(lc_a);
      dby_b <= prod_b + DBY_W'(lc_b);
      if (a_later) begin
        delta <= $signed({1'b0, doy_a}) - $signed({1'b0, doy_b});
      end else begin
        delta <= $signed({1'b0, doy_b}) - $signed({1'b0, doy_a});
      end
    end
    if (cmd.finish) begin
      day_difference <= result[OUT_W-1:0];
    end
  end

  assign span   = a_later ? (dby_a - dby_b) : (dby_b - dby_a);
  assign result = SUM_W'(span) + SUM_W'(delta);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

// ===== sv/ddd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ddd_ctrl
// Sequencer: load, divide, multiply, sum, then hand off the word.
// ----------------------------------------------------------------------------
`default_nettype none

module ddd_ctrl
  import ddd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire ddd_status_t status,
  output ddd_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // Wait here while the previous word still sits unclaimed.
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/ddd_checker.sv =====
// ----------------------------------------------------------------------------
// ddd_checker
// Port-level checks on the date day difference block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "date_day_difference_assert.svh"

module ddd_checker
  import ddd_pkg::*;
#(
  parameter int YEAR_BITS = 14
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic [YEAR_BITS-1:0] year_a,
  input wire logic [MONTH_W-1:0]   month_a,
  input wire logic [DAY_W-1:0]     day_a,
  input wire logic [YEAR_BITS-1:0] year_b,
  input wire logic [MONTH_W-1:0]   month_b,
  input wire logic [DAY_W-1:0]     day_b,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [OUT_W-1:0]     day_difference
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  `DDD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `DDD_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(day_difference))
  // The block works on one word at a time.
  `DDD_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall)
  // A word goes through divide, multiply and sum before any result appears.
  `DDD_ASSERT_NXT(a_no_instant_result, in_acc, !$rose(out_valid))

endmodule

bind date_day_difference ddd_checker #(.YEAR_BITS(YEAR_BITS)) u_ddd_checker (.*);

`default_nettype wire

// ===== tb/day_count_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// day_count_checker
// Watches both channels of the date day difference block. For every word
// taken in, it works out the day count between the two dates and queues it.
// Every word given out is compared with the oldest queued count. Mismatches
// and the number of counts still in flight are handed to the testbench top.
// ----------------------------------------------------------------------------
module day_count_checker
  import ddd_pkg::*;
#(
  parameter int YEAR_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [YEAR_BITS-1:0] year_a,
  input  logic [MONTH_W-1:0]   month_a,
  input  logic [DAY_W-1:0]     day_a,
  input  logic [YEAR_BITS-1:0] year_b,
  input  logic [MONTH_W-1:0]   month_b,
  input  logic [DAY_W-1:0]     day_b,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [OUT_W-1:0]     day_difference,
  output int                   mismatches,
  output int                   outstanding
);

  localparam int JANUARY   = 1;
  localparam int FEBRUARY  = 2;
  localparam int APRIL     = 4;
  localparam int JUNE      = 6;
  localparam int SEPTEMBER = 9;
  localparam int NOVEMBER  = 11;
  localparam int DECEMBER  = 12;

  logic [OUT_W-1:0] expected_days[$];

  function automatic bit leap_year(input longint y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // Days from the start of year zero up to the start of year y.
  function automatic longint days_to_year(input longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic longint days_in_month(input int m);
    if (m == FEBRUARY) begin
      return 28;
    end else if (m == APRIL || m == JUNE || m == SEPTEMBER || m == NOVEMBER) begin
      return 30;
    end
    return 31;
  endfunction

  // Month codes outside January to December add nothing and get no leap day.
  function automatic longint day_in_year(input longint y, input int m, input int d);
    longint total;
    total = d;
    if (m >= JANUARY && m <= DECEMBER) begin
      for (int k = JANUARY; k < m; k++) begin
        total += days_in_month(k);
      end
      if (m > FEBRUARY && leap_year(y)) begin
        total += 1;
      end
    end
    return total;
  endfunction

  function automatic logic [OUT_W-1:0] days_between(
    input longint ya, input int ma, input int da,
    input longint yb, input int mb, input int db
  );
    longint diff;
    if (ya <= yb) begin
      diff = days_to_year(yb) - days_to_year(ya) + day_in_year(yb, mb, db)
             - day_in_year(ya, ma, da);
    end else begin
      diff = days_to_year(ya) - days_to_year(yb) + day_in_year(ya, ma, da)
             - day_in_year(yb, mb, db);
    end
    return diff[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    logic [OUT_W-1:0] want;
    if (rst) begin
      expected_days.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      // Retire first so a word taken in this cycle is never matched against itself.
      if (out_valid && !out_stall) begin
        if (expected_days.size() == 0) begin
          $error("day_difference: word with nothing pending, actual %0d",
                 $signed(day_difference));
          mismatches <= mismatches + 1;
        end else begin
          want = expected_days.pop_front();
          if (want !== day_difference) begin
            $error("day_difference: expected %0d, actual %0d",
                   $signed(want), $signed(day_difference));
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_days.push_back(days_between(year_a, month_a, day_a,
                                             year_b, month_b, day_b));
      end
      outstanding <= expected_days.size();
    end
  end

endmodule

// ===== tb/date_day_difference_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_day_difference_tb
// Sends date pairs to the day difference block: a directed set covering
// leap rules, out-of-range months, zero days and extreme years, then random
// pairs. The sender works in bursts and the receiver stalls in patterns,
// with long hold-offs that back the block up. A separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module date_day_difference_tb;
  import ddd_pkg::*;

  localparam int YEAR_BITS    = 14;
  localparam int RANDOM_WORDS = 1630;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int YEAR_MAX     = (1 << YEAR_BITS) - 1;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [YEAR_BITS-1:0] year_a;
  logic [MONTH_W-1:0]   month_a;
  logic [DAY_W-1:0]     day_a;
  logic [YEAR_BITS-1:0] year_b;
  logic [MONTH_W-1:0]   month_b;
  logic [DAY_W-1:0]     day_b;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_W-1:0]     day_difference;
  int                   mismatches;
  int                   outstanding;
  int                   burst_left;
  int                   idle_cycles;

  date_day_difference #(
    .YEAR_BITS(YEAR_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .year_a        (year_a),
    .month_a       (month_a),
    .day_a         (day_a),
    .year_b        (year_b),
    .month_b       (month_b),
    .day_b         (day_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .day_difference(day_difference)
  );

  day_count_checker #(
    .YEAR_BITS(YEAR_BITS)
  ) day_count_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .year_a        (year_a),
    .month_a       (month_a),
    .day_a         (day_a),
    .year_b        (year_b),
    .month_b       (month_b),
    .day_b         (day_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .day_difference(day_difference),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one word and holds it until taken; then either goes on with the
  // burst or drops valid for a random gap.
  task automatic offer_word(
    input int ya, input int ma, input int da,
    input int yb, input int mb, input int db
  );
    int gap;
    in_valid <= 1'b1;
    year_a   <= ya[YEAR_BITS-1:0];
    month_a  <= ma[MONTH_W-1:0];
    day_a    <= da[DAY_W-1:0];
    year_b   <= yb[YEAR_BITS-1:0];
    month_b  <= mb[MONTH_W-1:0];
    day_b    <= db[DAY_W-1:0];
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Mostly well-formed dates, with same-year and neighboring-year pairs,
  // and some words drawn over the full width of every field.
  task automatic offer_random_word();
    int kind, ya, yb;
    kind = $urandom_range(0, 99);
    ya   = $urandom_range(1, 9999);
    if (kind < 55) begin
      offer_word(ya, $urandom_range(1, 12), $urandom_range(1, 31),
                 $urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 31));
    end else if (kind < 70) begin
      offer_word(ya, $urandom_range(1, 12), $urandom_range(1, 31),
                 ya, $urandom_range(1, 12), $urandom_range(1, 31));
    end else if (kind < 85) begin
      yb = ya + $urandom_range(0, 8) - 4;
      if (yb < 0) begin
        yb = 0;
      end
      offer_word(ya, $urandom_range(1, 12), $urandom_range(1, 31),
                 yb, $urandom_range(1, 12), $urandom_range(1, 31));
    end else begin
      offer_word($urandom_range(0, YEAR_MAX), $urandom_range(0, 15), $urandom_range(0, 31),
                 $urandom_range(0, YEAR_MAX), $urandom_range(0, 15), $urandom_range(0, 31));
    end
  endtask

  initial begin : stimulus
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    year_a     <= '0;
    month_a    <= '0;
    day_a      <= '0;
    year_b     <= '0;
    month_b    <= '0;
    day_b      <= '0;
    burst_left = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_word(2024, 1, 1, 2024, 12, 31);
    offer_word(2024, 12, 31, 2024, 1, 1);      // same year, negative result
    offer_word(2023, 2, 28, 2023, 3, 1);
    offer_word(1900, 3, 1, 2000, 3, 1);        // century and 400-year rules
    offer_word(2000, 2, 29, 2001, 3, 1);
    offer_word(2001, 1, 1, 2000, 1, 1);        // first year later
    offer_word(1, 1, 1, 9999, 12, 31);
    offer_word(9999, 12, 31, 1, 1, 1);
    offer_word(0, 3, 1, 0, 2, 28);             // year zero counts as leap
    offer_word(0, 0, 0, YEAR_MAX, 15, 31);     // widest span, still within the result width
    offer_word(YEAR_MAX, 15, 31, 0, 0, 0);
    offer_word(2020, 13, 5, 2020, 14, 5);      // month codes past December
    offer_word(2020, 0, 0, 2020, 15, 31);
    offer_word(2400, 3, 1, 2100, 3, 1);
    offer_word(1999, 12, 31, 2000, 1, 1);
    offer_word(8191, 8, 16, 8192, 7, 15);
    offer_word(5461, 5, 10, 10922, 10, 21);
    offer_word(400, 2, 29, 400, 3, 1);
    offer_word(100, 3, 1, 100, 2, 28);
    offer_word(YEAR_MAX, 1, 1, YEAR_MAX, 1, 1);

    repeat (RANDOM_WORDS) offer_random_word();
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // The receiver changes its stall pattern every segment and twice holds off
  // long enough for the block to fill and push back on the sender.
  initial begin : receiver
    stall_mode_t mode;
    int          seg_len;
    int          segments;
    int          tick;
    out_stall <= 1'b0;
    segments  = 0;
    tick      = 0;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      segments++;
      if (segments == 8 || segments == 40) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode    = stall_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(20, 300);
      repeat (seg_len) begin
        tick++;
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          default:        out_stall <= ((tick % 5) < 2);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ddd_pkg.sv
sv/ddd_div100.sv
sv/ddd_datapath.sv
sv/ddd_ctrl.sv
sv/date_day_difference.sv
sv/ddd_checker.sv
tb/day_count_checker.sv
tb/date_day_difference_tb.sv
